// ----- hw/rtl/argnorm_pkg.sv -----
package argnorm_pkg;

	localparam int MAX_NAME_LEN = 64;
	localparam int CNT_W = $clog2(MAX_NAME_LEN + 1);
	localparam int ADDR_W = $clog2(MAX_NAME_LEN);
	localparam int GRP_SPAN = 3;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NAME_LEN);
	localparam logic [CNT_W-1:0] NO_CLOSE = '1;

	localparam logic [7:0] CH_OPEN = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_START,
		ST_SKIP_RD,
		ST_SKIP_EV,
		ST_P1_RD,
		ST_P1_EV,
		ST_P1_NC,
		ST_SCAN_CHK,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_GRP,
		ST_GRP_EV,
		ST_CPY_RD,
		ST_CPY_EV,
		ST_NEXT_EV,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		RD_I,
		RD_I1,
		RD_J
	} rd_sel_t;

	typedef enum logic [1:0] {
		EM_DATA,
		EM_USCORE,
		EM_OPEN
	} emit_sel_t;

	typedef struct packed {
		logic      load;
		rd_sel_t   rd_sel;
		logic      i_clr;
		logic      i_inc;
		logic      i_add2;
		logic      j_from_i;
		logic      j_inc;
		logic      emit;
		emit_sel_t emit_sel;
		logic      finish;
	} cmd_t;

	typedef struct packed {
		logic first_bad;
		logic i_end;
		logic j_end;
		logic i_gt_j;
		logic grp_short;
		logic close_none;
		logic c_space;
		logic c_dot;
		logic c_open;
		logic c_close;
		logic c_nul;
		logic emit_ok;
		logic out_free;
	} status_t;

endpackage

// ----- hw/rtl/argnorm_ram.sv -----
module argnorm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/argnorm_ctrl.sv -----
module argnorm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 name_last,
	output logic                 in_stall,
	input  argnorm_pkg::status_t status,
	output argnorm_pkg::cmd_t    cmd
);

	argnorm_pkg::state_t st_q;
	argnorm_pkg::state_t st_d;
	logic arr_q;
	logic arr_d;
	logic open_q;
	logic open_d;
	argnorm_pkg::state_t nf_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= argnorm_pkg::ST_LOAD;
			arr_q <= 1'b0;
			open_q <= 1'b0;
		end else begin
			st_q <= st_d;
			arr_q <= arr_d;
			open_q <= open_d;
		end
	end

	// A failed search for a closing bracket ends the name in array mode.
	assign nf_st = arr_q ? argnorm_pkg::ST_FINISH : argnorm_pkg::ST_P1_NC;

	always_comb begin
		st_d = st_q;
		arr_d = arr_q;
		open_d = open_q;
		in_stall = 1'b1;
		cmd = '0;
		cmd.rd_sel = argnorm_pkg::RD_I;
		cmd.emit_sel = argnorm_pkg::EM_DATA;
		case (st_q)
			argnorm_pkg::ST_LOAD: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (name_last) begin
						st_d = argnorm_pkg::ST_START;
					end
				end
			end
			argnorm_pkg::ST_START: begin
				arr_d = 1'b0;
				open_d = 1'b0;
				cmd.i_clr = 1'b1;
				st_d = status.first_bad ? argnorm_pkg::ST_FINISH : argnorm_pkg::ST_SKIP_RD;
			end
			argnorm_pkg::ST_SKIP_RD: begin
				st_d = status.i_end ? argnorm_pkg::ST_FINISH : argnorm_pkg::ST_SKIP_EV;
			end
			argnorm_pkg::ST_SKIP_EV: begin
				if (status.c_space) begin
					cmd.i_inc = 1'b1;
					st_d = argnorm_pkg::ST_SKIP_RD;
				end else begin
					st_d = argnorm_pkg::ST_P1_EV;
				end
			end
			argnorm_pkg::ST_P1_RD: begin
				st_d = status.i_end ? argnorm_pkg::ST_FINISH : argnorm_pkg::ST_P1_EV;
			end
			argnorm_pkg::ST_P1_EV: begin
				if (status.c_open && !open_q) begin
					st_d = argnorm_pkg::ST_SCAN_CHK;
				end else if (status.emit_ok) begin
					cmd.emit = 1'b1;
					if (!open_q && (status.c_space || status.c_dot)) begin
						cmd.emit_sel = argnorm_pkg::EM_USCORE;
					end
					cmd.i_inc = 1'b1;
					st_d = argnorm_pkg::ST_P1_RD;
				end
			end
			argnorm_pkg::ST_P1_NC: begin
				if (status.emit_ok) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = argnorm_pkg::EM_USCORE;
					cmd.i_inc = 1'b1;
					open_d = 1'b1;
					st_d = argnorm_pkg::ST_P1_RD;
				end
			end
			argnorm_pkg::ST_SCAN_CHK: begin
				cmd.j_from_i = 1'b1;
				st_d = status.close_none ? nf_st : argnorm_pkg::ST_SCAN_RD;
			end
			argnorm_pkg::ST_SCAN_RD: begin
				cmd.rd_sel = argnorm_pkg::RD_J;
				st_d = status.j_end ? nf_st : argnorm_pkg::ST_SCAN_EV;
			end
			argnorm_pkg::ST_SCAN_EV: begin
				cmd.rd_sel = argnorm_pkg::RD_J;
				if (status.c_nul) begin
					st_d = nf_st;
				end else if (status.c_close) begin
					arr_d = 1'b1;
					st_d = argnorm_pkg::ST_GRP;
				end else begin
					cmd.j_inc = 1'b1;
					st_d = argnorm_pkg::ST_SCAN_RD;
				end
			end
			argnorm_pkg::ST_GRP: begin
				cmd.rd_sel = argnorm_pkg::RD_I1;
				st_d = status.grp_short ? argnorm_pkg::ST_GRP_EV : argnorm_pkg::ST_CPY_RD;
			end
			argnorm_pkg::ST_GRP_EV: begin
				cmd.rd_sel = argnorm_pkg::RD_I1;
				if (!status.c_space) begin
					st_d = argnorm_pkg::ST_CPY_RD;
				end else if (status.emit_ok) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = argnorm_pkg::EM_OPEN;
					cmd.i_add2 = 1'b1;
					st_d = argnorm_pkg::ST_CPY_RD;
				end
			end
			argnorm_pkg::ST_CPY_RD: begin
				if (!status.i_gt_j) begin
					st_d = argnorm_pkg::ST_CPY_EV;
				end else if (status.i_end) begin
					st_d = argnorm_pkg::ST_FINISH;
				end else begin
					st_d = argnorm_pkg::ST_NEXT_EV;
				end
			end
			argnorm_pkg::ST_CPY_EV: begin
				if (status.emit_ok) begin
					cmd.emit = 1'b1;
					cmd.i_inc = 1'b1;
					st_d = argnorm_pkg::ST_CPY_RD;
				end
			end
			argnorm_pkg::ST_NEXT_EV: begin
				st_d = status.c_open ? argnorm_pkg::ST_SCAN_CHK : argnorm_pkg::ST_FINISH;
			end
			argnorm_pkg::ST_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					st_d = argnorm_pkg::ST_LOAD;
				end
			end
			default: begin
				st_d = argnorm_pkg::ST_LOAD;
			end
		endcase
	end

endmodule

// ----- hw/rtl/argnorm_dp.sv -----
module argnorm_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  argnorm_pkg::cmd_t    cmd,
	input  logic [7:0]           name_byte,
	input  logic                 out_stall,
	output argnorm_pkg::status_t status,
	output logic                 out_valid,
	output logic [7:0]           out_byte,
	output logic                 out_last,
	output logic                 out_empty,
	output logic                 overflow
);

	logic [argnorm_pkg::CNT_W-1:0]  fill_q;
	logic [argnorm_pkg::CNT_W-1:0]  close_q;
	logic                           ovf_q;
	logic [7:0]                     first_q;
	logic [argnorm_pkg::CNT_W-1:0]  i_q;
	logic [argnorm_pkg::CNT_W-1:0]  j_q;
	logic [argnorm_pkg::CNT_W-1:0]  i_next1;
	logic [7:0]                     pend_q;
	logic                           pend_valid_q;
	logic                           out_valid_q;
	logic [7:0]                     out_byte_q;
	logic                           out_last_q;
	logic                           out_empty_q;
	logic                           out_ovf_q;
	logic                           we;
	logic [argnorm_pkg::ADDR_W-1:0] raddr;
	logic [7:0]                     rdata;
	logic [7:0]                     emit_byte;
	logic                           out_free;
	logic                           out_load;

	assign we = cmd.load && (fill_q < argnorm_pkg::MAX_CNT);
	assign i_next1 = i_q + argnorm_pkg::CNT_W'(1);

	always_comb begin
		case (cmd.rd_sel)
			argnorm_pkg::RD_I: raddr = i_q[argnorm_pkg::ADDR_W-1:0];
			argnorm_pkg::RD_I1: raddr = i_next1[argnorm_pkg::ADDR_W-1:0];
			argnorm_pkg::RD_J: raddr = j_q[argnorm_pkg::ADDR_W-1:0];
			default: raddr = i_q[argnorm_pkg::ADDR_W-1:0];
		endcase
	end

	argnorm_ram #(
		.WIDTH(8),
		.DEPTH(argnorm_pkg::MAX_NAME_LEN)
	) u_store (
		.clk(clk),
		.we(we),
		.waddr(fill_q[argnorm_pkg::ADDR_W-1:0]),
		.wdata(name_byte),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		case (cmd.emit_sel)
			argnorm_pkg::EM_DATA: emit_byte = rdata;
			argnorm_pkg::EM_USCORE: emit_byte = argnorm_pkg::CH_USCORE;
			argnorm_pkg::EM_OPEN: emit_byte = argnorm_pkg::CH_OPEN;
			default: emit_byte = rdata;
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (cmd.emit && pend_valid_q) || cmd.finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			close_q <= argnorm_pkg::NO_CLOSE;
			ovf_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (fill_q < argnorm_pkg::MAX_CNT) begin
					fill_q <= fill_q + argnorm_pkg::CNT_W'(1);
					if (name_byte == argnorm_pkg::CH_CLOSE) begin
						close_q <= fill_q;
					end
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.i_clr) begin
				i_q <= '0;
			end else if (cmd.i_inc) begin
				i_q <= i_next1;
			end else if (cmd.i_add2) begin
				i_q <= i_q + argnorm_pkg::CNT_W'(2);
			end
			if (cmd.j_from_i) begin
				j_q <= i_q;
			end else if (cmd.j_inc) begin
				j_q <= j_q + argnorm_pkg::CNT_W'(1);
			end
			if (cmd.emit) begin
				pend_valid_q <= 1'b1;
			end
			if (cmd.finish) begin
				fill_q <= '0;
				close_q <= argnorm_pkg::NO_CLOSE;
				ovf_q <= 1'b0;
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && fill_q == '0) begin
			first_q <= name_byte;
		end
		if (cmd.emit) begin
			pend_q <= emit_byte;
		end
		if (out_load) begin
			out_byte_q <= (cmd.finish && !pend_valid_q) ? 8'h00 : pend_q;
			out_last_q <= cmd.finish;
			out_empty_q <= cmd.finish && !pend_valid_q;
			out_ovf_q <= ovf_q;
		end
	end

	assign status.first_bad = (first_q == argnorm_pkg::CH_OPEN) ||
		(first_q == argnorm_pkg::CH_EQ);
	assign status.i_end = i_q >= fill_q;
	assign status.j_end = j_q >= fill_q;
	assign status.i_gt_j = i_q > j_q;
	assign status.grp_short = (j_q + argnorm_pkg::CNT_W'(1)) ==
		(i_q + argnorm_pkg::CNT_W'(argnorm_pkg::GRP_SPAN));
	assign status.close_none = (close_q == argnorm_pkg::NO_CLOSE) || (close_q < i_q);
	assign status.c_space = rdata == argnorm_pkg::CH_SPACE;
	assign status.c_dot = rdata == argnorm_pkg::CH_DOT;
	assign status.c_open = rdata == argnorm_pkg::CH_OPEN;
	assign status.c_close = rdata == argnorm_pkg::CH_CLOSE;
	assign status.c_nul = rdata == argnorm_pkg::CH_NUL;
	assign status.emit_ok = !pend_valid_q || out_free;
	assign status.out_free = out_free;

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;
	assign out_empty = out_empty_q;
	assign overflow = out_ovf_q;

endmodule

// ----- hw/rtl/php_arg_name_normalizer_unit.sv -----
// Loading takes one input item per cycle; bytes past the 64-entry store are dropped.
// After the final item, normalization reads the store through one registered read port,
// scanning and emitting bytes and searching each group for its closing bracket
// before it finishes; no input is taken meanwhile.
// Asynchronous active-low reset clears the controller, counters, flags and output valid;
// the store contents are not cleared and are only read where written for the current name.
module php_arg_name_normalizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] name_byte,
	input  logic       name_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       out_empty,
	output logic       overflow
);

	argnorm_pkg::cmd_t    cmd;
	argnorm_pkg::status_t status;

	argnorm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.name_last(name_last),
		.in_stall(in_stall),
		.status(status),
		.cmd(cmd)
	);

	argnorm_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.name_byte(name_byte),
		.out_stall(out_stall),
		.status(status),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.out_last(out_last),
		.out_empty(out_empty),
		.overflow(overflow)
	);

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT = 800000;
	localparam int ITEM_TARGET = 420;
	localparam int DRAIN_CYCLES = 400;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
		logic       empty;
		logic       ovf;
	} norm_out_t;

	typedef enum logic [1:0] {
		RX_FLOW,
		RX_SPARSE,
		RX_PERIODIC,
		RX_HEAVY
	} rx_mode_t;

	class name_pred;
		logic [7:0] store [argnorm_pkg::MAX_NAME_LEN];
		int         fill = 0;
		int         close_at = int'(argnorm_pkg::NO_CLOSE);
		bit         ovf_seen = 0;
		logic [7:0] cooked [$];
		norm_out_t  want_q [$];
		int         errors = 0;

		function int find_close(int pos, int n);
			if (close_at == int'(argnorm_pkg::NO_CLOSE) || close_at < pos)
				return -1;
			for (int j = pos; j < n; j++) begin
				if (store[j] == argnorm_pkg::CH_NUL)
					return -1;
				if (store[j] == argnorm_pkg::CH_CLOSE)
					return j;
			end
			return -1;
		endfunction

		function void normalize();
			int  n;
			int  i;
			int  j;
			int  stop;
			bit  open_seen;
			bit  arr;
			n = fill;
			i = 0;
			open_seen = 0;
			arr = 0;
			cooked.delete();
			if (n == 0)
				return;
			if (store[0] == argnorm_pkg::CH_OPEN || store[0] == argnorm_pkg::CH_EQ)
				return;
			while (i < n && store[i] == argnorm_pkg::CH_SPACE)
				i++;
			while (i < n) begin
				if (store[i] == argnorm_pkg::CH_OPEN && !open_seen) begin
					if (find_close(i, n) >= 0) begin
						arr = 1;
						break;
					end
					cooked.push_back(argnorm_pkg::CH_USCORE);
					open_seen = 1;
				end else if (!open_seen && (store[i] == argnorm_pkg::CH_SPACE ||
						store[i] == argnorm_pkg::CH_DOT)) begin
					cooked.push_back(argnorm_pkg::CH_USCORE);
				end else begin
					cooked.push_back(store[i]);
				end
				i++;
			end
			if (arr) begin
				while (1) begin
					j = find_close(i, n);
					if (j < 0)
						break;
					stop = j + 1;
					if (stop - i == argnorm_pkg::GRP_SPAN &&
							store[i + 1] == argnorm_pkg::CH_SPACE) begin
						cooked.push_back(argnorm_pkg::CH_OPEN);
						i += 2;
					end
					while (i < stop && cooked.size() < argnorm_pkg::MAX_NAME_LEN) begin
						cooked.push_back(store[i]);
						i++;
					end
					if (i >= n || store[i] != argnorm_pkg::CH_OPEN)
						break;
				end
			end
		endfunction

		function void take_byte(logic [7:0] b, logic fin);
			norm_out_t item;
			if (fill < argnorm_pkg::MAX_NAME_LEN) begin
				store[fill] = b;
				if (b == argnorm_pkg::CH_CLOSE)
					close_at = fill;
				fill++;
			end else begin
				ovf_seen = 1;
			end
			if (!fin)
				return;
			normalize();
			if (cooked.size() == 0) begin
				item = '{data: 8'h00, fin: 1'b1, empty: 1'b1, ovf: ovf_seen};
				want_q.push_back(item);
			end else begin
				foreach (cooked[q]) begin
					item = '{data: cooked[q], fin: (q == cooked.size() - 1),
						empty: 1'b0, ovf: ovf_seen};
					want_q.push_back(item);
				end
			end
			fill = 0;
			close_at = int'(argnorm_pkg::NO_CLOSE);
			ovf_seen = 0;
		endfunction

		function void cmp_field(string what, int want, int got);
			if (want != got) begin
				$display("%0t: %s expected %0d got %0d", $time, what, want, got);
				errors++;
			end
		endfunction

		function void check_out(logic [7:0] data, logic fin, logic empty, logic ovf);
			norm_out_t want;
			if (want_q.size() == 0) begin
				$display("%0t: unexpected item, expected none got byte %0d last %b",
					$time, data, fin);
				$display("%0t: unexpected item, empty %b overflow %b", $time, empty, ovf);
				errors++;
				return;
			end
			want = want_q.pop_front();
			cmp_field("out_byte", want.data, data);
			cmp_field("out_last", want.fin, fin);
			cmp_field("out_empty", want.empty, empty);
			cmp_field("overflow", want.ovf, ovf);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] name_byte = 8'h00;
	logic       name_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;
	logic       out_empty;
	logic       overflow;

	name_pred   pred;
	logic [7:0] name_q [$];
	int         burst_left = 0;
	int         sent_items = 0;
	rx_mode_t   rx_mode = RX_FLOW;
	int         rx_left = 0;
	int         rx_phase = 0;

	php_arg_name_normalizer_unit i_dut (.*);

	initial forever #6 clk = ~clk;

	initial begin
		int unsigned cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("tb: FAIL");
		$finish;
	end

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 150);
		end else begin
			rx_left--;
		end
		rx_phase++;
		case (rx_mode)
			RX_FLOW: out_stall <= 1'b0;
			RX_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
			RX_PERIODIC: out_stall <= ((rx_phase % 5) < 2);
			RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
			default: out_stall <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			pred.check_out(out_byte, out_last, out_empty, overflow);
	end

	task automatic push_item(input logic [7:0] b, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 1'b1;
		name_byte <= b;
		name_last <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pred.take_byte(b, fin);
		sent_items++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_name();
		foreach (name_q[k])
			push_item(name_q[k], k == name_q.size() - 1);
	endtask

	task automatic send_text(input string s);
		name_q.delete();
		for (int k = 0; k < s.len(); k++)
			name_q.push_back(s[k]);
		send_name();
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pred.want_q.size() != 0);
	endtask

	function automatic logic [7:0] word_char();
		case ($urandom_range(0, 7))
			0: return argnorm_pkg::CH_SPACE;
			1: return argnorm_pkg::CH_DOT;
			2: return 8'($urandom_range(48, 57));
			default: return 8'($urandom_range(97, 122));
		endcase
	endfunction

	function automatic logic [7:0] any_char();
		case ($urandom_range(0, 11))
			0: return argnorm_pkg::CH_OPEN;
			1: return argnorm_pkg::CH_CLOSE;
			2: return argnorm_pkg::CH_SPACE;
			3: return argnorm_pkg::CH_DOT;
			4: return argnorm_pkg::CH_EQ;
			5: return argnorm_pkg::CH_NUL;
			6: return argnorm_pkg::CH_USCORE;
			7, 8: return 8'($urandom_range(97, 122));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void make_name();
		int shape;
		int len;
		name_q.delete();
		shape = $urandom_range(0, 11);
		if (shape < 7) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2)) name_q.push_back(argnorm_pkg::CH_SPACE);
			if ($urandom_range(0, 9) == 0)
				name_q.push_back($urandom_range(0, 1) ? argnorm_pkg::CH_OPEN :
					argnorm_pkg::CH_EQ);
			repeat ($urandom_range(1, 5)) name_q.push_back(word_char());
			repeat ($urandom_range(0, 3)) begin
				name_q.push_back(argnorm_pkg::CH_OPEN);
				case ($urandom_range(0, 5))
					0: name_q.push_back(argnorm_pkg::CH_SPACE);
					1: ;
					2: begin
						name_q.push_back(word_char());
						name_q.push_back(argnorm_pkg::CH_NUL);
					end
					default: repeat ($urandom_range(1, 3)) name_q.push_back(word_char());
				endcase
				if ($urandom_range(0, 7) != 0)
					name_q.push_back(argnorm_pkg::CH_CLOSE);
			end
			repeat ($urandom_range(0, 2)) name_q.push_back(any_char());
		end else if (shape < 11) begin
			repeat ($urandom_range(1, 10)) name_q.push_back(any_char());
		end else begin
			case ($urandom_range(0, 3))
				0: len = argnorm_pkg::MAX_NAME_LEN - 1;
				1: len = argnorm_pkg::MAX_NAME_LEN;
				2: len = argnorm_pkg::MAX_NAME_LEN + 1;
				default: len = $urandom_range(argnorm_pkg::MAX_NAME_LEN + 2,
					argnorm_pkg::MAX_NAME_LEN + 26);
			endcase
			repeat (len)
				name_q.push_back(($urandom_range(0, 3) == 0) ? any_char() : word_char());
		end
	endfunction

	initial begin
		int name_no;
		pred = new;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_text("[");
		send_text("=");
		send_text(" .a b");
		send_text("x[ ][1]z");
		send_text("a[b");
		name_q = '{8'h61, argnorm_pkg::CH_OPEN, 8'h62, argnorm_pkg::CH_NUL,
			argnorm_pkg::CH_CLOSE};
		send_name();
		name_q = '{8'hFF};
		send_name();
		name_q = '{argnorm_pkg::CH_NUL};
		send_name();
		drain_results();

		// A name one byte longer than the store is sent first, then the mix goes random.
		name_q.delete();
		repeat (argnorm_pkg::MAX_NAME_LEN + 1) name_q.push_back(word_char());
		send_name();
		name_no = 0;
		while (sent_items < ITEM_TARGET) begin
			make_name();
			send_name();
			name_no++;
			if (name_no % 12 == 5)
				drain_results();
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pred.errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/argnorm_pkg.sv
hw/rtl/argnorm_ram.sv
hw/rtl/argnorm_ctrl.sv
hw/rtl/argnorm_dp.sv
hw/rtl/php_arg_name_normalizer_unit.sv
bench/tb.sv
